FILE: sv/tdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types, codes and sizes of the timer deadline queue
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int MaxTimers = 16;
  localparam int MaxFires  = 16;
  localparam int SlotW     = $clog2(MaxTimers);
  localparam int FireCntW  = $clog2(MaxFires + 1);
  localparam int FireIdxW  = $clog2(MaxFires);
  localparam int TimeW     = 48;
  localparam int IdW       = 32;
  localparam int PeriodW   = 32;

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpService = 2'd2;
  localparam logic [1:0] OpNop     = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [TimeW-1:0]   deadline;
    logic [PeriodW-1:0] period;
    logic [IdW-1:0]     target_id;
    logic [TimeW-1:0]   now;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   assigned_id;
    logic             fired_valid;
    logic [IdW-1:0]   fired_id;
    logic             last;
    logic             armed;
    logic [TimeW-1:0] next_deadline;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic add;
    logic scan_init;
    logic scan_sum;
    logic scan_step;
    logic remove;
    logic fire;
    logic emit_next;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       found;
    logic       fire_last;
    logic       emit_last;
  } dp_stat_t;

endpackage

FILE: sv/timer_deadline_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue_core
// table of software timers with add, remove and deadline-ordered service
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | request   | in_valid_i / in_ready_o  | in_req_i  (in_req_t)
// out     | result    | out_valid_o / out_ready_i| out_rsp_o (out_rsp_t)
//
// one request at a time; every table walk visits one slot per cycle
// add / no-op: load, dispatch (add applied), summary walk, then the result
// remove: load, dispatch, search walk, apply (clear if found), summary walk
// service: load, dispatch, search + apply per pass, summary walk, results; one pass
//   per fired timer plus a closing pass that finds nothing, none after the 16th
// reset clears the valid map and the id counter at once, no sweep
// results hold while out_ready_i is low; no new request until the last goes
// ----------------------------------------------------------------------------
module timer_deadline_queue_core import tdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: dispatch per operation, scan loop, summary walk, result drain
  tdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // slots, best-candidate registers, fired id buffer and summary
  tdq_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

FILE: sv/tdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_datapath
// timer slots, scan unit, fired-id buffer and result fields
// ----------------------------------------------------------------------------
module tdq_datapath import tdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output out_rsp_t out_rsp_o
);

  logic [MaxTimers-1:0] valid_q, valid_d;
  logic [IdW-1:0]       ident_q  [MaxTimers];
  logic [TimeW-1:0]     dl_q     [MaxTimers];
  logic [PeriodW-1:0]   per_q    [MaxTimers];
  logic [MaxTimers-1:0] done_q;
  logic [IdW-1:0]       fifo_q   [MaxFires];

  in_req_t              req_q;
  logic [IdW-1:0]       idc_q;
  logic [1:0]           st_q;
  logic [IdW-1:0]       aid_q;
  logic [SlotW-1:0]     idx_q;
  logic                 sum_q;
  logic                 found_q;
  logic [SlotW-1:0]     best_q;
  logic [TimeW-1:0]     best_dl_q;
  logic [IdW-1:0]       best_id_q;
  logic [PeriodW-1:0]   best_per_q;
  logic                 any_q;
  logic [TimeW-1:0]     early_q;
  logic [FireCntW-1:0]  n_q;
  logic [FireCntW-1:0]  k_q;

  // lowest free slot
  logic                 free_ok;
  logic [SlotW-1:0]     free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = MaxTimers - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // current scan slot
  logic             cur_v;
  logic [TimeW-1:0] cur_dl;
  logic [IdW-1:0]   cur_id;
  logic             cand, better, rm_hit;
  assign cur_v  = valid_q[idx_q];
  assign cur_dl = dl_q[idx_q];
  assign cur_id = ident_q[idx_q];
  assign cand   = cur_v && !done_q[idx_q] && (cur_dl <= req_q.now);
  assign better = !found_q || (cur_dl < best_dl_q) ||
                  ((cur_dl == best_dl_q) && (cur_id < best_id_q));
  assign rm_hit = !found_q && cur_v && (cur_id == req_q.target_id);

  logic [TimeW:0]   resched_sum;
  logic [TimeW-1:0] resched;
  assign resched_sum = {1'b0, req_q.now} + {{(TimeW + 1 - PeriodW){1'b0}}, best_per_q};
  assign resched     = resched_sum[TimeW] ? {TimeW{1'b1}} : resched_sum[TimeW-1:0];

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.add && (req_q.operation == OpAdd) && free_ok) valid_d[free_idx] = 1'b1;
    if (cmd_i.remove && found_q) valid_d[best_q] = 1'b0;
    if (cmd_i.fire && best_per_q == '0) valid_d[best_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idc_q   <= '0;
      idx_q   <= '0;
      sum_q   <= 1'b0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
      n_q     <= '0;
      k_q     <= '0;
      done_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.load) begin
        n_q    <= '0;
        done_q <= '0;
      end
      if (cmd_i.add && free_ok) idc_q <= idc_q + 1'b1;
      if (cmd_i.fire) begin
        done_q[best_q] <= 1'b1;
        n_q            <= n_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        idx_q   <= '0;
        sum_q   <= cmd_i.scan_sum;
        found_q <= 1'b0;
        any_q   <= 1'b0;
        k_q     <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (sum_q) begin
          if (cur_v && (!any_q || cur_dl < early_q)) any_q <= 1'b1;
        end else if (req_q.operation == OpRemove) begin
          if (rm_hit) found_q <= 1'b1;
        end else if (cand && better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.emit_next) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
      st_q  <= StOk;
      aid_q <= '0;
    end
    if (cmd_i.add) begin
      if (free_ok) begin
        ident_q[free_idx] <= idc_q + 1'b1;
        dl_q[free_idx]    <= req_q.deadline;
        per_q[free_idx]   <= req_q.period;
        aid_q             <= idc_q + 1'b1;
      end else begin
        st_q <= StFull;
      end
    end
    if (cmd_i.remove && !found_q) st_q <= StNotFound;
    if (cmd_i.fire) begin
      fifo_q[n_q[FireIdxW-1:0]] <= best_id_q;
      if (best_per_q != '0) dl_q[best_q] <= resched;
    end
    if (cmd_i.scan_step) begin
      if (sum_q) begin
        if (cur_v && (!any_q || cur_dl < early_q)) early_q <= cur_dl;
      end else if (req_q.operation == OpRemove) begin
        if (rm_hit) best_q <= idx_q;
      end else if (cand && better) begin
        best_q     <= idx_q;
        best_dl_q  <= cur_dl;
        best_id_q  <= cur_id;
        best_per_q <= per_q[idx_q];
      end
    end
  end

  logic [FireCntW-1:0] cnt;
  assign cnt = (n_q == '0) ? FireCntW'(1) : n_q;

  assign stat_o.op        = req_q.operation;
  assign stat_o.scan_last = (idx_q == SlotW'(MaxTimers - 1));
  assign stat_o.found     = found_q;
  assign stat_o.fire_last = (n_q == FireCntW'(MaxFires - 1));
  assign stat_o.emit_last = (k_q == cnt - 1'b1);

  assign out_rsp_o.status        = st_q;
  assign out_rsp_o.assigned_id   = aid_q;
  assign out_rsp_o.fired_valid   = (n_q != '0);
  assign out_rsp_o.fired_id      = (n_q != '0) ? fifo_q[k_q[FireIdxW-1:0]] : '0;
  assign out_rsp_o.last          = stat_o.emit_last;
  assign out_rsp_o.armed         = any_q;
  assign out_rsp_o.next_deadline = any_q ? early_q : '0;

endmodule

FILE: sv/tdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl
// sequencer for add, remove, service and summary scans
// ----------------------------------------------------------------------------
module tdq_ctrl import tdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDisp  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StApply = 3'd3;
  localparam logic [2:0] StSum   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDisp;
        end
      end
      StDisp: begin
        cmd_o.scan_init = 1'b1;
        if (stat_i.op == OpRemove || stat_i.op == OpService) begin
          state_d = StScan;
        end else begin
          cmd_o.add      = (stat_i.op == OpAdd);
          cmd_o.scan_sum = 1'b1;
          state_d        = StSum;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = StApply;
      end
      StApply: begin
        cmd_o.scan_init = 1'b1;
        if (stat_i.op == OpRemove) begin
          cmd_o.remove   = 1'b1;
          cmd_o.scan_sum = 1'b1;
          state_d        = StSum;
        end else if (stat_i.found && !stat_i.fire_last) begin
          cmd_o.fire = 1'b1;
          state_d    = StScan;
        end else begin
          cmd_o.fire     = stat_i.found;
          cmd_o.scan_sum = 1'b1;
          state_d        = StSum;
        end
      end
      StSum: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (stat_i.emit_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/tdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_checker
// port-level checks on the timer deadline queue
// ----------------------------------------------------------------------------
module tdq_checker import tdq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while results pending");

  a_no_fire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.fired_valid |-> out_rsp_o.last)
    else $error("non-fire result not last");

  a_idle_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.armed |-> out_rsp_o.next_deadline == '0)
    else $error("deadline reported with nothing armed");

endmodule

bind timer_deadline_queue_core tdq_checker u_tdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: tb/sv/timer_deadline_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue_core_tb
// self-checking bench for the timer deadline queue
// ----------------------------------------------------------------------------
// a driver sends add, remove, service and no-op requests, with random gaps,
// from a queue that an initial block fills. A behavioral copy of the timer
// table predicts every result. A monitor with random stalls compares each
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_deadline_queue_core_tb;
  import tdq_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;

  timer_deadline_queue_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predicted copy of the timer table
  logic               tbl_valid [MaxTimers];
  logic [IdW-1:0]     tbl_id    [MaxTimers];
  logic [TimeW-1:0]   tbl_dl    [MaxTimers];
  logic [PeriodW-1:0] tbl_per   [MaxTimers];
  logic [IdW-1:0]     id_ctr;

  in_req_t  pending_reqs[$];
  out_rsp_t expected_rsps[$];
  int       err_cnt = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       hold_send = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // push predicted results for one accepted request
  task automatic predict_timer_op(input in_req_t r);
    out_rsp_t   res[$];
    out_rsp_t   one;
    logic       fired [MaxTimers];
    logic       any;
    logic [TimeW-1:0] earliest;
    logic [TimeW:0]   sum;
    int         idx;
    int         best;
    res = {};
    one = '0;
    one.last = 1'b1;
    case (r.operation)
      OpAdd: begin
        idx = -1;
        for (int i = 0; i < MaxTimers; i++)
          if (!tbl_valid[i] && idx < 0) idx = i;
        if (idx < 0) begin
          one.status = StFull;
        end else begin
          id_ctr = id_ctr + 1;
          tbl_valid[idx] = 1'b1;
          tbl_id[idx] = id_ctr;
          tbl_dl[idx] = r.deadline;
          tbl_per[idx] = r.period;
          one.assigned_id = id_ctr;
        end
        res.push_back(one);
      end
      OpRemove: begin
        idx = -1;
        for (int i = 0; i < MaxTimers; i++)
          if (tbl_valid[i] && tbl_id[i] == r.target_id && idx < 0) idx = i;
        if (idx < 0) one.status = StNotFound;
        else tbl_valid[idx] = 1'b0;
        res.push_back(one);
      end
      OpService: begin
        for (int i = 0; i < MaxTimers; i++) fired[i] = 1'b0;
        for (int n = 0; n < MaxFires; n++) begin
          best = -1;
          for (int i = 0; i < MaxTimers; i++) begin
            if (tbl_valid[i] && !fired[i] && tbl_dl[i] <= r.now) begin
              if (best < 0 || tbl_dl[i] < tbl_dl[best] ||
                  (tbl_dl[i] == tbl_dl[best] && tbl_id[i] < tbl_id[best]))
                best = i;
            end
          end
          if (best < 0) break;
          fired[best] = 1'b1;
          one = '0;
          one.fired_valid = 1'b1;
          one.fired_id = tbl_id[best];
          res.push_back(one);
          if (tbl_per[best] != '0) begin
            sum = {1'b0, r.now} + tbl_per[best];
            tbl_dl[best] = sum[TimeW] ? '1 : sum[TimeW-1:0];
          end else begin
            tbl_valid[best] = 1'b0;
          end
        end
        if (res.size() == 0) begin
          one = '0;
          res.push_back(one);
        end
        res[res.size()-1].last = 1'b1;
      end
      default: res.push_back(one);
    endcase
    any = 1'b0;
    earliest = '0;
    for (int i = 0; i < MaxTimers; i++)
      if (tbl_valid[i] && (!any || tbl_dl[i] < earliest)) begin
        earliest = tbl_dl[i];
        any = 1'b1;
      end
    foreach (res[k]) begin
      res[k].armed = any;
      res[k].next_deadline = earliest;
      expected_rsps.push_back(res[k]);
    end
  endtask

  // mostly short gaps, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // queue for issued ids; the bench never fills or reads it
  logic [IdW-1:0] issued_ids[$];

  function automatic in_req_t mk_req(input logic [1:0] op, input logic [TimeW-1:0] dl,
                                     input logic [PeriodW-1:0] per,
                                     input logic [IdW-1:0] tid,
                                     input logic [TimeW-1:0] now);
    in_req_t r;
    r.operation = op;
    r.deadline  = dl;
    r.period    = per;
    r.target_id = tid;
    r.now       = now;
    return r;
  endfunction

  function automatic logic [TimeW-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TimeW-1:0];
  endfunction

  // stimulus
  logic [TimeW-1:0] clock_ms;
  initial begin
    int p;
    clock_ms = 48'd1000;
    // directed: empty-table cases, extremes, full table, saturation
    pending_reqs.push_back(mk_req(OpService, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(OpRemove, '0, '0, '1, '0));
    pending_reqs.push_back(mk_req(OpNop, '1, '1, '1, '1));
    pending_reqs.push_back(mk_req(OpAdd, '1, '1, '0, '0));
    pending_reqs.push_back(mk_req(OpAdd, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(OpAdd, 48'd5, 32'd0, '0, '0));
    pending_reqs.push_back(mk_req(OpAdd, 48'd5, 32'd7, '0, '0));
    for (int i = 0; i < 13; i++)  // fills the table, the last one reports full
      pending_reqs.push_back(mk_req(OpAdd, 48'd100 + i, i[0] ? 32'hFFFF_FFFF : 0, '0, '0));
    pending_reqs.push_back(mk_req(OpRemove, '0, '0, 32'd3, '0));
    pending_reqs.push_back(mk_req(OpService, '0, '0, '0, 48'd110));
    // saturated reschedule stays expired until the next service
    pending_reqs.push_back(mk_req(OpService, '0, '0, '0, '1));
    pending_reqs.push_back(mk_req(OpService, '0, '0, '0, '1));
    pending_reqs.push_back(mk_req(OpNop, '0, '0, '0, '0));

    // random: mostly adds with near deadlines and services at advancing time
    for (int n = 0; n < 450; n++) begin
      p = $urandom_range(99);
      if (p < 38) begin
        pending_reqs.push_back(mk_req(OpAdd,
          ($urandom_range(9) == 0) ? rand48() : clock_ms + $urandom_range(300),
          ($urandom_range(2) == 0) ? 32'd0 :
          ($urandom_range(9) == 0) ? $urandom() : $urandom_range(200, 1),
          $urandom(), rand48()));
      end else if (p < 58) begin
        pending_reqs.push_back(mk_req(OpRemove, rand48(), $urandom(),
          ($urandom_range(3) == 0) ? $urandom() : $urandom_range(n + 20), rand48()));
      end else if (p < 94) begin
        clock_ms = clock_ms + $urandom_range(150);
        pending_reqs.push_back(mk_req(OpService, rand48(), $urandom(), $urandom(),
          ($urandom_range(30) == 0) ? rand48() : clock_ms));
      end else begin
        pending_reqs.push_back(mk_req(OpNop, rand48(), $urandom(), $urandom(), rand48()));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one request per gap, held until accepted
  int send_gap = 0;
  int sent_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_timer_op(in_req_i);
        sent_cnt++;
        if (sent_cnt == 30) hold_send = 1'b1;
      end
      if (hold_send && expected_rsps.size() == 0 && !(in_valid_i && in_ready_o))
        hold_send = 1'b0;
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0 || hold_send || pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
          if (pending_reqs.size() == 0 && !hold_send) stim_done = 1'b1;
        end else begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_reqs.pop_front();
          send_gap = gap_len();
        end
      end
    end
  end

  // monitor: random stalls on the result side
  int stall = 0;
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp_o.status != want.status)
            report_mismatch($sformatf("status %0d exp %0d", out_rsp_o.status, want.status));
          if (out_rsp_o.assigned_id != want.assigned_id)
            report_mismatch($sformatf("assigned_id %0d exp %0d",
              out_rsp_o.assigned_id, want.assigned_id));
          if (out_rsp_o.fired_valid != want.fired_valid)
            report_mismatch("fired_valid");
          if (out_rsp_o.fired_id != want.fired_id)
            report_mismatch($sformatf("fired_id %0d exp %0d", out_rsp_o.fired_id, want.fired_id));
          if (out_rsp_o.last != want.last)
            report_mismatch("last");
          if (out_rsp_o.armed != want.armed)
            report_mismatch("armed");
          if (out_rsp_o.next_deadline != want.next_deadline)
            report_mismatch($sformatf("next_deadline %0h exp %0h",
              out_rsp_o.next_deadline, want.next_deadline));
        end
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = gap_len();
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (stim_done && expected_rsps.size() == 0 && !in_valid_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < MaxTimers; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_dl[i] = '0;
      tbl_per[i] = '0;
    end
    id_ctr = '0;
  end

endmodule
